// ----- hdl/lcd_mode_timing_and_stat_core_macros.svh -----
// Assertion macros shared by the LCD mode timing RTL.
// No dependencies; included by modules that carry assertions.
`ifndef LCD_MODE_TIMING_AND_STAT_CORE_MACROS_SVH
`define LCD_MODE_TIMING_AND_STAT_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LMTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LMTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/lmts_pkg.sv -----
// Types, codes and timing constants for the LCD mode timing and STAT block.
// No dependencies.
package lmts_pkg;

  // bus / tick operation codes
  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_WR_CTRL   = 3'd1,
    OP_WR_STAT   = 3'd2,
    OP_WR_CMP    = 3'd3,
    OP_WR_LINE   = 3'd4,
    OP_RD_STAT   = 3'd5,
    OP_RD_CMP    = 3'd6,
    OP_RD_LINE   = 3'd7
  } op_e;

  // scanline modes
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_DRAW   = 2'd3;

  // irq enable bit positions
  localparam int unsigned EN_HBLANK = 0;
  localparam int unsigned EN_VBLANK = 1;
  localparam int unsigned EN_OAM    = 2;
  localparam int unsigned EN_COINC  = 3;

  localparam logic [8:0] DUR_HBLANK = 9'd204;
  localparam logic [8:0] DUR_VBLANK = 9'd456;
  localparam logic [8:0] DUR_OAM    = 9'd80;
  localparam logic [8:0] DUR_DRAW   = 9'd172;

  localparam logic [7:0] VISIBLE_LINES = 8'd144;
  localparam logic [8:0] LAST_LINE     = 9'd153;

  typedef struct packed {
    op_e        opcode;
    logic [7:0] elapsed_cycles;
    logic [7:0] write_data;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       vblank_irq;
    logic       stat_irq;
    logic       draw_request;
    logic [7:0] drawn_line;
  } res_t;

  function automatic logic [8:0] mode_length(input logic [1:0] mode);
    logic [8:0] len;
    case (mode)
      MODE_HBLANK: len = DUR_HBLANK;
      MODE_VBLANK: len = DUR_VBLANK;
      MODE_OAM:    len = DUR_OAM;
      default:     len = DUR_DRAW;
    endcase
    return len;
  endfunction

endpackage

// ----- hdl/lcd_mode_timing_and_stat_core.sv -----
// Top level of the LCD mode timing and STAT block: input stage, sequencer, result register.
// Depends on lmts_pkg, lmts_in_stage, lmts_seq.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------------
//  in      | input     | in_valid_i / in_stall_o | opcode_i, elapsed_cycles_i, write_data_i
//  out     | output    | out_valid_o / out_stall_i | read_data_o, vblank_irq_o, stat_irq_o,
//          |           |                        | draw_request_o, drawn_line_o
//
// One word per cycle sustained while out is not stalled; each accepted word gives one
// result word, passing through the input register, then the sequencer's update into the
// result register. Reset (rst_ni low, async) clears handshake and mode/line state.
// A stalled result holds in the output register while the input register keeps the
// next word; input stalls only when both registers are full and out is stalled.
module lcd_mode_timing_and_stat_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] opcode_i,
  input  logic [7:0] elapsed_cycles_i,
  input  logic [7:0] write_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic       vblank_irq_o,
  output logic       stat_irq_o,
  output logic       draw_request_o,
  output logic [7:0] drawn_line_o
);

  lmts_pkg::item_t in_item, s1_item;
  lmts_pkg::res_t  res, res_q;
  logic            s1_valid;
  logic            advance;
  logic            out_valid_q, out_valid_d;

  assign in_item.opcode         = lmts_pkg::op_e'(opcode_i);
  assign in_item.elapsed_cycles = elapsed_cycles_i;
  assign in_item.write_data     = write_data_i;

  // the held word moves on once the result register is free or draining
  assign advance = s1_valid && (!out_valid_q || !out_stall_i);

  lmts_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .stall_o   (in_stall_o),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  lmts_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (advance),
    .item_i (s1_item),
    .res_o  (res)
  );

  // result register
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = res_q.read_data;
  assign vblank_irq_o   = res_q.vblank_irq;
  assign stat_irq_o     = res_q.stat_irq;
  assign draw_request_o = res_q.draw_request;
  assign drawn_line_o   = res_q.drawn_line;

endmodule

// ----- hdl/lmts_in_stage.sv -----
// Input register stage: captures one word and holds it until the sequencer takes it.
// Depends on lmts_pkg.
module lmts_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          stall_o,
  input  lmts_pkg::item_t item_i,
  input  logic          advance_i,
  output logic          valid_o,
  output lmts_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  lmts_pkg::item_t item_q, item_d;
  logic            load;

  assign stall_o = valid_q && !advance_i;
  assign load    = valid_i && !stall_o;

  always_comb begin
    valid_d = load || (valid_q && !advance_i);
    item_d  = load ? item_i : item_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- hdl/lmts_seq.sv -----
// Mode sequencer, line counter and register file; computes one result per word.
// Depends on lmts_pkg and the assertion macro header.
`include "lcd_mode_timing_and_stat_core_macros.svh"

module lmts_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            go_i,
  input  lmts_pkg::item_t item_i,
  output lmts_pkg::res_t  res_o
);

  logic [1:0]  mode_q, mode_d;
  logic [15:0] acc_q, acc_d;
  logic [7:0]  line_q, line_d;
  logic [7:0]  cmp_q, cmp_d;
  logic [3:0]  en_q, en_d;
  logic        disp_q, disp_d;

  logic [15:0] acc_sum;
  logic [8:0]  target;
  logic        fire;
  logic [7:0]  line_inc;
  logic [8:0]  line_next9;
  lmts_pkg::res_t res;

  assign acc_sum    = acc_q + {8'd0, item_i.elapsed_cycles};
  assign target     = lmts_pkg::mode_length(mode_q);
  assign fire       = acc_sum >= {7'd0, target};
  assign line_inc   = line_q + 8'd1;
  assign line_next9 = {1'b0, line_q} + 9'd1;

  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    line_d = line_q;
    cmp_d  = cmp_q;
    en_d   = en_q;
    disp_d = disp_q;
    res    = '0;
    case (item_i.opcode)
      lmts_pkg::OP_TICK: begin
        if (disp_q) begin
          acc_d = acc_sum;
          if (fire) begin
            acc_d = acc_sum - {7'd0, target};
            case (mode_q)
              lmts_pkg::MODE_HBLANK: begin
                line_d = line_inc;
                if (en_q[lmts_pkg::EN_COINC] && line_inc == cmp_q) begin
                  res.stat_irq = 1'b1;
                end
                if (line_inc == lmts_pkg::VISIBLE_LINES) begin
                  mode_d         = lmts_pkg::MODE_VBLANK;
                  res.vblank_irq = 1'b1;
                  if (en_q[lmts_pkg::EN_VBLANK]) begin
                    res.stat_irq = 1'b1;
                  end
                end else begin
                  mode_d = lmts_pkg::MODE_OAM;
                end
              end
              lmts_pkg::MODE_VBLANK: begin
                if (line_next9 > lmts_pkg::LAST_LINE) begin
                  mode_d       = lmts_pkg::MODE_OAM;
                  line_d       = 8'd0;
                  res.stat_irq = en_q[lmts_pkg::EN_OAM];
                end else begin
                  line_d = line_next9[7:0];
                end
              end
              lmts_pkg::MODE_OAM: begin
                mode_d = lmts_pkg::MODE_DRAW;
              end
              default: begin
                mode_d           = lmts_pkg::MODE_HBLANK;
                res.draw_request = 1'b1;
                res.drawn_line   = line_q;
                res.stat_irq     = en_q[lmts_pkg::EN_HBLANK];
              end
            endcase
          end
        end
      end
      lmts_pkg::OP_WR_CTRL: begin
        disp_d = item_i.write_data[7];
        if (!item_i.write_data[7]) begin
          line_d = 8'd0;
          mode_d = lmts_pkg::MODE_HBLANK;
        end
      end
      lmts_pkg::OP_WR_STAT: en_d   = item_i.write_data[6:3];
      lmts_pkg::OP_WR_CMP:  cmp_d  = item_i.write_data;
      lmts_pkg::OP_WR_LINE: line_d = 8'd0;
      lmts_pkg::OP_RD_STAT: res.read_data = {1'b0, en_q, line_q == cmp_q, mode_q};
      lmts_pkg::OP_RD_CMP:  res.read_data = cmp_q;
      default:              res.read_data = line_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= lmts_pkg::MODE_HBLANK;
      acc_q  <= 16'd0;
      line_q <= 8'd0;
      cmp_q  <= 8'd0;
      en_q   <= 4'd0;
      disp_q <= 1'b0;
    end else if (go_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      line_q <= line_d;
      cmp_q  <= cmp_d;
      en_q   <= en_d;
      disp_q <= disp_d;
    end
  end

  assign res_o = res;

  // frozen display: a tick leaves line, mode and accumulator alone
  `LMTS_ASSERT_NEXT(a_tick_frozen, clk_i, rst_ni,
    go_i && item_i.opcode == lmts_pkg::OP_TICK && !disp_q,
    $stable(line_q) && $stable(mode_q) && $stable(acc_q), "tick changed state while display off")
  // vblank interrupt always lands the sequencer in vblank
  `LMTS_ASSERT_NEXT(a_vblank_mode, clk_i, rst_ni, go_i && res.vblank_irq,
    mode_q == lmts_pkg::MODE_VBLANK, "vblank irq without vblank mode")
  // end of draw always goes to hblank
  `LMTS_ASSERT_NEXT(a_draw_hblank, clk_i, rst_ni, go_i && res.draw_request,
    mode_q == lmts_pkg::MODE_HBLANK && $past(mode_q) == lmts_pkg::MODE_DRAW,
    "draw request not from draw to hblank")

endmodule
